// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTT estimator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define RTTE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RTTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rtte_pkg.sv =====
// ----------------------------------------------------------------------------
// RTT estimator package
// Widths, reset values, command codes and register indexes of the
// retransmit timeout estimator.
// ----------------------------------------------------------------------------
package rtte_pkg;

  // Sample width used by the estimators
  localparam int SAMPLE_BITS = 32;
  localparam int SRTT_W      = SAMPLE_BITS + 4;
  localparam int DEV_W       = SAMPLE_BITS + 3;
  // Working width: holds a saturating sum and a doubled 32-bit timeout
  localparam int WIDE_W      = (SAMPLE_BITS + 5 > 33) ? SAMPLE_BITS + 5 : 33;

  localparam logic [WIDE_W-1:0] SAMPLE_MAX_W =
    WIDE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [WIDE_W-1:0] SRTT_MAX_W =
    WIDE_W'((64'd1 << SRTT_W) - 64'd1);
  localparam logic [WIDE_W-1:0] DEV_MAX_W =
    WIDE_W'((64'd1 << DEV_W) - 64'd1);

  // Reset and restart values
  localparam logic [DEV_W-1:0]  DEV_RESET     = DEV_W'(750000);
  localparam logic [WIDE_W-1:0] RESTART_RTO_W = WIDE_W'(3000000);
  localparam logic [31:0]       RTO_MIN_RESET = 32'd1000000;
  localparam logic [31:0]       RTO_MAX_RESET = 32'd3000000;
  // Restart timeout clamped by the reset bounds
  localparam logic [31:0]       TIMEOUT_RESET = 32'd3000000;

  // Microseconds to seconds: x / 1000000 = (x >> 6) / 15625, done as a
  // multiply by ceil(2^40 / 15625), exact for any 26-bit operand
  localparam int           SEC_PRE_SHIFT = 6;
  localparam int           SEC_OP_W      = 32 - SEC_PRE_SHIFT;
  localparam int           SEC_MUL_W     = 27;
  localparam int           SEC_SHIFT     = 40;
  localparam int           SEC_PROD_W    = SEC_OP_W + SEC_MUL_W;
  localparam logic [SEC_MUL_W-1:0] SEC_MUL = 27'd70368745;
  localparam int           SEC_W         = 13;

  // Command codes
  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_BACKOFF = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Register indexes (byte address bit 2)
  localparam logic REG_RTO_MIN = 1'b0;
  localparam logic REG_RTO_MAX = 1'b1;

  localparam int PADDR_W = 3;
  localparam int TDATA_IN_W  = 32;
  localparam int TUSER_IN_W  = 8;
  localparam int TDATA_OUT_W = 80;

endpackage

// ===== rtl/rtt_retransmit_timeout_estimator.sv =====
// ----------------------------------------------------------------------------
// RTT retransmit timeout estimator
// Smoothed RTT / mean deviation tracker that produces a clamped timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer per event. s_tuser carries the command
//   (measure, timeout backoff, restart); s_tdata carries the measured round
//   trip in microseconds, used only by a measure.
//   Output stream (m_*): one transfer per input transfer, in order, with the
//   clamped timeout in microseconds, the same timeout in whole seconds and
//   the last measured sample.
//   APB port: register 0 (address 0x0) is the lower timeout bound, register
//   1 (address 0x4) the upper bound. Write them only while the block is idle.
// Timing:
//   Three register stages: input register, estimator update (state and
//   clamp together in stage B), seconds conversion (one multiply). One
//   transfer is taken per cycle while the output is not stalled; the
//   estimator update within stage B lets dependent events follow each other
//   back to back.
// Reset: bounds return to 1 s and 3 s, estimators to zero and 750000, the
//   timeout to 3 s, and the pipeline empties.
// Stall: when m_tready is low, the stages fill up and s_tready falls once all
//   three hold an item; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtt_retransmit_timeout_estimator
  import rtte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [31:0] measured_us
  input  logic [TUSER_IN_W-1:0]  s_tuser,   // [1:0] cmd, [7:2] zero
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [31:0] rto_us, [44:32] rto_seconds,
                                            // [76:45] last_rtt_us, [79:77] zero
  // APB configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration
  logic [31:0] rto_min;
  logic [31:0] rto_max;
  logic        cfg_write;

  // Pipeline stages
  logic        a_valid;
  cmd_t        a_cmd;
  logic [31:0] a_meas;
  logic        b_valid;
  logic        c_valid;
  logic [31:0] c_rto;
  logic [SEC_W-1:0] c_sec;
  logic [31:0] c_last;
  logic        en_a;
  logic        en_b;
  logic        en_c;
  logic        load_b;
  logic        load_c;

  // Estimator state
  logic [SRTT_W-1:0] srtt;
  logic [DEV_W-1:0]  dev;
  logic [31:0]       timeout;
  logic [31:0]       last_sample;

  logic [SRTT_W-1:0] srtt_next;
  logic [DEV_W-1:0]  dev_next;
  logic [31:0]       timeout_next;
  logic [31:0]       last_sample_next;

  // Update datapath
  logic [WIDE_W-1:0] meas_w;
  logic [WIDE_W-1:0] samp;
  logic [WIDE_W-1:0] srtt_w;
  logic [WIDE_W-1:0] dev_w;
  logic [WIDE_W-1:0] avg;
  logic [WIDE_W-1:0] quarter;
  logic              samp_ge;
  logic [WIDE_W-1:0] err;
  logic [WIDE_W-1:0] srtt_sum;
  logic [WIDE_W-1:0] srtt_upd;
  logic [WIDE_W-1:0] dev_sum;
  logic [WIDE_W-1:0] dev_upd;
  logic [WIDE_W-1:0] est_rto;
  logic [WIDE_W-1:0] clamp_in;
  logic [31:0]       clamp_out;

  // Seconds conversion
  logic [SEC_PROD_W-1:0] sec_prod;

  // When the bounds cross, a value below the lower bound gets the lower bound and any other value the upper
  function automatic logic [31:0] clamp_rto(input logic [WIDE_W-1:0] v,
                                            input logic [31:0] lo,
                                            input logic [31:0] hi);
    logic [31:0] r;
    if (v < WIDE_W'(lo)) begin
      r = lo;
    end else if (v > WIDE_W'(hi)) begin
      r = hi;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rto_min <= RTO_MIN_RESET;
      rto_max <= RTO_MAX_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RTO_MIN: rto_min <= pwdata;
        REG_RTO_MAX: rto_max <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RTO_MIN: prdata = rto_min;
      REG_RTO_MAX: prdata = rto_max;
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage advances when empty or when the next one advances
  // --------------------------------------------------------------------------
  assign en_c     = !c_valid || m_tready;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign s_tready = en_a;
  assign load_b   = en_b && a_valid;
  assign load_c   = en_c && b_valid;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && s_tvalid) begin
      a_cmd  <= cmd_t'(s_tuser[1:0]);
      a_meas <= s_tdata[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Estimator update
  // --------------------------------------------------------------------------
  always_comb begin
    // Saturate the sample to the estimator width
    meas_w  = WIDE_W'(a_meas);
    samp    = (meas_w > SAMPLE_MAX_W) ? SAMPLE_MAX_W : meas_w;
    srtt_w  = WIDE_W'(srtt);
    dev_w   = WIDE_W'(dev);
    avg     = srtt_w >> 3;
    quarter = dev_w >> 2;

    // Smoothed RTT: gain 1/8, saturating upward
    samp_ge  = samp >= avg;
    err      = samp_ge ? (samp - avg) : (avg - samp);
    srtt_sum = srtt_w + err;
    if (samp_ge) begin
      srtt_upd = (srtt_sum > SRTT_MAX_W) ? SRTT_MAX_W : srtt_sum;
    end else begin
      srtt_upd = srtt_w - err;
    end

    // Mean deviation: gain 1/4, saturating upward
    dev_sum = dev_w + err - quarter;
    if (err >= quarter) begin
      dev_upd = (dev_sum > DEV_MAX_W) ? DEV_MAX_W : dev_sum;
    end else begin
      dev_upd = dev_w - (quarter - err);
    end

    est_rto = (srtt_upd >> 3) + dev_upd;
  end

  // Select the unclamped timeout and the next state per command
  always_comb begin
    srtt_next        = srtt;
    dev_next         = dev;
    last_sample_next = last_sample;
    clamp_in         = WIDE_W'(timeout);
    case (a_cmd)
      CMD_MEASURE: begin
        srtt_next        = srtt_upd[SRTT_W-1:0];
        dev_next         = dev_upd[DEV_W-1:0];
        last_sample_next = a_meas;
        clamp_in         = est_rto;
      end
      CMD_BACKOFF: begin
        clamp_in = WIDE_W'(timeout) << 1;
      end
      CMD_RESTART: begin
        srtt_next        = '0;
        dev_next         = DEV_RESET;
        last_sample_next = '0;
        clamp_in         = RESTART_RTO_W;
      end
      default: ;
    endcase
    clamp_out    = clamp_rto(clamp_in, rto_min, rto_max);
    // An unused command leaves the timeout untouched
    timeout_next = (a_cmd == CMD_NONE) ? timeout : clamp_out;
  end

  // State doubles as the stage B result
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      srtt        <= '0;
      dev         <= DEV_RESET;
      timeout     <= TIMEOUT_RESET;
      last_sample <= '0;
    end else begin
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (load_b) begin
        srtt        <= srtt_next;
        dev         <= dev_next;
        timeout     <= timeout_next;
        last_sample <= last_sample_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Seconds conversion and output register
  // --------------------------------------------------------------------------
  assign sec_prod = SEC_PROD_W'(timeout[31:SEC_PRE_SHIFT]) * SEC_PROD_W'(SEC_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      c_rto  <= timeout;
      c_sec  <= sec_prod[SEC_SHIFT +: SEC_W];
      c_last <= last_sample;
    end
  end

  assign m_tvalid = c_valid;
  assign m_tdata  = {3'b000, c_last, c_sec, c_rto};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An unused command keeps the old timeout, which may sit outside new bounds
  `RTTE_ASSERT(a_clamp_bounds, clk, rst,
    (load_b && a_cmd != CMD_NONE) |=> ($past(rto_min) > $past(rto_max)) ||
               (timeout >= $past(rto_min) && timeout <= $past(rto_max)),
    "timeout outside configured bounds")

  `RTTE_ASSERT(a_restart_state, clk, rst,
    (load_b && a_cmd == CMD_RESTART) |=>
      (srtt == '0 && dev == DEV_RESET && last_sample == '0),
    "restart did not reload estimators")

  `RTTE_ASSERT(a_stall_full, clk, rst,
    !s_tready |-> (a_valid && b_valid && c_valid),
    "input stalled with an empty stage")

  `RTTE_ASSERT(a_out_capture, clk, rst,
    load_c |=> (c_rto == $past(timeout) && c_last == $past(last_sample)),
    "output register did not capture stage B")

endmodule
